@@ rtl/joystick_differential_drive_mixer_defines.svh @@
// Assertion macros shared by the mixer checker.
`ifndef JOYSTICK_DIFFERENTIAL_DRIVE_MIXER_DEFINES_SVH
`define JOYSTICK_DIFFERENTIAL_DRIVE_MIXER_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define JDDM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mixer check failed");

// Next-cycle implication, quiet during reset.
`define JDDM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mixer check failed");

// Next-cycle implication that also holds across reset.
`define JDDM_ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mixer check failed");

`endif

@@ rtl/jddm_pkg.sv @@
// Types and constants of the joystick differential drive mixer.
package jddm_pkg;

  localparam int RawW  = 11;
  localparam int DbW   = 8;
  localparam int QW    = 16;
  localparam int NumW  = 30;
  localparam int DenW  = 16;
  localparam int IdxW  = 2;

  localparam logic [IdxW-1:0] REG_RC_MIN   = 2'd0;
  localparam logic [IdxW-1:0] REG_RC_MAX   = 2'd1;
  localparam logic [IdxW-1:0] REG_DEADBAND = 2'd2;

  localparam logic signed [31:0] Q_ONE = 32'sd16384;

  typedef struct packed {
    logic [RawW-1:0] rc_min;
    logic [RawW-1:0] rc_max;
    logic [DbW-1:0]  deadband;
  } cfg_t;

  typedef enum logic [1:0] {
    DIV_MAP_X   = 2'd0,
    DIV_MAP_Y   = 2'd1,
    DIV_SCALE_X = 2'd2,
    DIV_SCALE_Y = 2'd3
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     div_start;
    logic     div_store;
    div_sel_t div_sel;
    logic     sq_first;
    logic     sq_second;
    logic     sqrt_init;
    logic     sqrt_step;
    logic     commit;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic need_scale;
    logic out_free;
  } sts_t;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_MX_GO = 14'b00000000000010,
    S_MX_WT = 14'b00000000000100,
    S_MY_GO = 14'b00000000001000,
    S_MY_WT = 14'b00000000010000,
    S_SQ1   = 14'b00000000100000,
    S_SQ2   = 14'b00000001000000,
    S_RT_GO = 14'b00000010000000,
    S_RT_WT = 14'b00000100000000,
    S_SX_GO = 14'b00001000000000,
    S_SX_WT = 14'b00010000000000,
    S_SY_GO = 14'b00100000000000,
    S_SY_WT = 14'b01000000000000,
    S_MIX   = 14'b10000000000000
  } state_t;

endpackage

@@ rtl/jddm_if.sv @@
// Channel interfaces of the mixer: stick input, drive output, configuration.
interface jddm_in_if import jddm_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [RawW-1:0] steer_raw;
  logic [RawW-1:0] throttle_raw;
  modport source (output valid, steer_raw, throttle_raw, input ready);
  modport sink   (input valid, steer_raw, throttle_raw, output ready);
endinterface

interface jddm_out_if import jddm_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [DbW-1:0] left_speed;
  logic [DbW-1:0] right_speed;
  logic           left_reverse;
  logic           right_reverse;
  logic           left_dir_changed;
  logic           right_dir_changed;
  modport source (output valid, left_speed, right_speed, left_reverse, right_reverse,
                  left_dir_changed, right_dir_changed, input ready);
  modport sink   (input valid, left_speed, right_speed, left_reverse, right_reverse,
                  left_dir_changed, right_dir_changed, output ready);
endinterface

interface jddm_cfg_if import jddm_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [IdxW-1:0] index;
  logic [RawW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/jddm_div.sv @@
// Restoring divider, one quotient bit a cycle, sign applied at the end.
module jddm_div import jddm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [NumW-1:0]        num,
  input  logic [DenW-1:0]        den,
  input  logic                   neg,
  output logic                   done,
  output logic signed [NumW:0]   quo
);

  localparam int CntW = $clog2(NumW);

  logic            busy;
  logic [CntW-1:0] cnt;
  logic [NumW-1:0] q;
  logic [DenW-1:0] rem;
  logic [DenW-1:0] d;
  logic            sgn;
  logic [DenW:0]   trial;

  assign trial = {rem, q[NumW-1]} - {1'b0, d};
  assign quo   = sgn ? -$signed({1'b0, q}) : $signed({1'b0, q});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(NumW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= num;
      rem <= '0;
      d   <= den;
      sgn <= neg;
    end else if (busy) begin
      // keep the remainder when the trial subtract goes negative
      if (!trial[DenW]) begin
        rem <= trial[DenW-1:0];
        q   <= {q[NumW-2:0], 1'b1};
      end else begin
        rem <= {rem[DenW-2:0], q[NumW-1]};
        q   <= {q[NumW-2:0], 1'b0};
      end
    end
  end

endmodule

@@ rtl/jddm_dp.sv @@
// Mixer datapath: axis mapping, radius, scaling, mixing and track state.
module jddm_dp import jddm_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  cfg_t            cfg,
  input  cmd_t            cmd,
  output sts_t            sts,
  input  logic [RawW-1:0] steer_raw,
  input  logic [RawW-1:0] throttle_raw,
  input  logic            out_ready,
  output logic            out_valid,
  output logic [DbW-1:0]  left_speed,
  output logic [DbW-1:0]  right_speed,
  output logic            left_reverse,
  output logic            right_reverse,
  output logic            left_dir_changed,
  output logic            right_dir_changed
);

  logic [RawW-1:0]        steer, throttle;
  logic signed [QW-1:0]   x, y, xs, ys;
  logic [31:0]            r2;
  logic [31:0]            sq_n, sq_res, sq_bit, sq_sum;
  logic [3:0]             sq_cnt;
  logic                   left_dir, right_dir;

  // divider operands
  logic [RawW-1:0]        raw_sel;
  logic signed [RawW:0]   diff, den_s;
  logic [RawW:0]          diff_mag, den_mag;
  logic signed [QW:0]     xy_sel;
  logic [QW:0]            xy_mag;
  logic [NumW-1:0]        div_num;
  logic [DenW-1:0]        div_den;
  logic                   div_neg;
  logic                   div_done;
  logic signed [NumW:0]   div_quo;
  logic signed [NumW+1:0] mapped;
  logic signed [QW-1:0]   mapped_sat;

  assign raw_sel  = (cmd.div_sel == DIV_MAP_X) ? steer : throttle;
  assign diff     = $signed({1'b0, raw_sel}) - $signed({1'b0, cfg.rc_min});
  assign den_s    = $signed({1'b0, cfg.rc_max}) - $signed({1'b0, cfg.rc_min});
  assign diff_mag = diff[RawW] ? 12'(-diff) : 12'(diff);
  assign den_mag  = den_s[RawW] ? 12'(-den_s) : 12'(den_s);
  assign xy_sel   = (cmd.div_sel == DIV_SCALE_X) ? 17'(x) : 17'(y);
  assign xy_mag   = xy_sel[QW] ? 17'(-xy_sel) : 17'(xy_sel);

  always_comb begin
    unique case (cmd.div_sel)
      DIV_MAP_X, DIV_MAP_Y: begin
        div_num = NumW'({diff_mag[RawW-1:0], 15'b0});
        div_den = DenW'(den_mag[RawW-1:0]);
        div_neg = diff[RawW] ^ den_s[RawW];
      end
      default: begin
        div_num = {xy_mag[QW-1:0], 14'b0};
        div_den = sq_res[DenW-1:0];
        div_neg = xy_sel[QW];
      end
    endcase
  end

  jddm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .neg   (div_neg),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign mapped = 32'(div_quo) - Q_ONE;
  always_comb begin
    if (den_s == '0)                 mapped_sat = '0;
    else if (mapped > 32'sd32767)    mapped_sat = 16'sh7fff;
    else if (mapped < -32'sd32768)   mapped_sat = 16'sh8000;
    else                             mapped_sat = mapped[QW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      steer    <= steer_raw;
      throttle <= throttle_raw;
    end
    if (cmd.div_store) begin
      unique case (cmd.div_sel)
        DIV_MAP_X:   begin x <= mapped_sat; xs <= mapped_sat; end
        DIV_MAP_Y:   begin y <= mapped_sat; ys <= mapped_sat; end
        DIV_SCALE_X: xs <= div_quo[QW-1:0];
        DIV_SCALE_Y: ys <= div_quo[QW-1:0];
      endcase
    end
    if (cmd.sq_first)  r2 <= 32'(x * x);
    if (cmd.sq_second) r2 <= r2 + 32'(y * y);
  end

  // integer square root, two radicand bits a cycle
  assign sq_sum = sq_res + sq_bit;
  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      sq_n   <= r2;
      sq_res <= '0;
      sq_bit <= 32'h4000_0000;
      sq_cnt <= '0;
    end else if (cmd.sqrt_step) begin
      if (sq_n >= sq_sum) begin
        sq_n   <= sq_n - sq_sum;
        sq_res <= (sq_res >> 1) + sq_bit;
      end else begin
        sq_res <= sq_res >> 1;
      end
      sq_bit <= sq_bit >> 2;
      sq_cnt <= sq_cnt + 1'b1;
    end
  end

  // mix
  logic signed [QW+1:0] sum_l, sum_r;
  logic signed [QW-1:0] cl, cr, cmd_l, cmd_r;

  function automatic logic signed [QW-1:0] clip_one(input logic signed [QW+1:0] v);
    if (v > 18'sd16384)       return 16'sd16384;
    else if (v < -18'sd16384) return -16'sd16384;
    else                      return v[QW-1:0];
  endfunction

  assign sum_l = 18'(ys) + 18'(xs);
  assign sum_r = 18'(ys) - 18'(xs);
  assign cl    = clip_one(sum_l);
  assign cr    = clip_one(sum_r);
  assign cmd_l = (cl <= 0 && cr <= 0) ? cr : cl;
  assign cmd_r = (cl <= 0 && cr <= 0) ? cl : cr;

  logic [QW-1:0]  mag_l, mag_r;
  logic [23:0]    prod_l, prod_r;
  logic [DbW-1:0] v_l, v_r;
  logic           act_l, act_r, dir_l, dir_r;

  assign mag_l  = cmd_l[QW-1] ? 16'(-cmd_l) : 16'(cmd_l);
  assign mag_r  = cmd_r[QW-1] ? 16'(-cmd_r) : 16'(cmd_r);
  assign prod_l = 24'(mag_l) * 24'd255;
  assign prod_r = 24'(mag_r) * 24'd255;
  assign v_l    = prod_l[21:14];
  assign v_r    = prod_r[21:14];
  assign act_l  = v_l > cfg.deadband;
  assign act_r  = v_r > cfg.deadband;
  assign dir_l  = act_l ? cmd_l[QW-1] : left_dir;
  assign dir_r  = act_r ? cmd_r[QW-1] : right_dir;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      left_dir  <= 1'b0;
      right_dir <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
      left_dir  <= dir_l;
      right_dir <= dir_r;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      left_speed        <= act_l ? v_l : '0;
      right_speed       <= act_r ? v_r : '0;
      left_reverse      <= dir_l;
      right_reverse     <= dir_r;
      left_dir_changed  <= dir_l != left_dir;
      right_dir_changed <= dir_r != right_dir;
    end
  end

  assign sts.div_done   = div_done;
  assign sts.sqrt_done  = sq_cnt == 4'd15;
  assign sts.need_scale = r2 > 32'h1000_0000;
  assign sts.out_free   = !out_valid || out_ready;

endmodule

@@ rtl/jddm_ctrl.sv @@
// Mixer sequencer: steps the datapath through one stick word.
module jddm_ctrl import jddm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign in_ready = (state == S_IDLE) && !rst;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.div_sel = DIV_MAP_X;
    unique case (state)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_next = S_MX_GO;
      end
      S_MX_GO: begin cmd.div_start = 1'b1; state_next = S_MX_WT; end
      S_MX_WT: begin
        cmd.div_store = sts.div_done;
        if (sts.div_done) state_next = S_MY_GO;
      end
      S_MY_GO: begin
        cmd.div_sel = DIV_MAP_Y; cmd.div_start = 1'b1; state_next = S_MY_WT;
      end
      S_MY_WT: begin
        cmd.div_sel = DIV_MAP_Y; cmd.div_store = sts.div_done;
        if (sts.div_done) state_next = S_SQ1;
      end
      S_SQ1: begin cmd.sq_first = 1'b1; state_next = S_SQ2; end
      S_SQ2: begin cmd.sq_second = 1'b1; state_next = S_RT_GO; end
      S_RT_GO: begin
        cmd.sqrt_init = sts.need_scale;
        state_next = sts.need_scale ? S_RT_WT : S_MIX;
      end
      S_RT_WT: begin
        cmd.sqrt_step = 1'b1;
        if (sts.sqrt_done) state_next = S_SX_GO;
      end
      S_SX_GO: begin
        cmd.div_sel = DIV_SCALE_X; cmd.div_start = 1'b1; state_next = S_SX_WT;
      end
      S_SX_WT: begin
        cmd.div_sel = DIV_SCALE_X; cmd.div_store = sts.div_done;
        if (sts.div_done) state_next = S_SY_GO;
      end
      S_SY_GO: begin
        cmd.div_sel = DIV_SCALE_Y; cmd.div_start = 1'b1; state_next = S_SY_WT;
      end
      S_SY_WT: begin
        cmd.div_sel = DIV_SCALE_Y; cmd.div_store = sts.div_done;
        if (sts.div_done) state_next = S_MIX;
      end
      S_MIX: begin
        // hold until the output register can take the word
        cmd.commit = sts.out_free;
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ rtl/joystick_differential_drive_mixer.sv @@
// Top level of the single-stick differential drive mixer.
// One stick word (steer, throttle) gives one drive word (speeds, directions,
// change flags). A stick word inside the unit circle needs only the two
// divisions of the axis mapping on the shared one-bit-a-cycle divider; one
// that must be scaled back onto it also passes the square root and two more
// divisions for scaling. One word is in work at a time; a new stick word is
// taken as soon as the previous one is in the output register, even while
// that drive word still waits for the sink. Configuration writes are taken
// whenever reset is low and should be made while no word is in flight.
module joystick_differential_drive_mixer import jddm_pkg::*; (
  input logic       clk,
  input logic       rst,
  jddm_in_if.sink   stick,
  jddm_out_if.source drive,
  jddm_cfg_if.sink  cfg
);

  cfg_t cfg_regs;
  cmd_t cmd;
  sts_t sts;

  // configuration registers, indexes beyond the list are dropped
  assign cfg.ready = !rst;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.rc_min   <= 11'd172;
      cfg_regs.rc_max   <= 11'd1811;
      cfg_regs.deadband <= 8'd10;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_RC_MIN:   cfg_regs.rc_min   <= cfg.data;
        REG_RC_MAX:   cfg_regs.rc_max   <= cfg.data;
        REG_DEADBAND: cfg_regs.deadband <= cfg.data[DbW-1:0];
        default: ;
      endcase
    end
  end

  jddm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (stick.valid),
    .in_ready (stick.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  jddm_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg_regs),
    .cmd               (cmd),
    .sts               (sts),
    .steer_raw         (stick.steer_raw),
    .throttle_raw      (stick.throttle_raw),
    .out_ready         (drive.ready),
    .out_valid         (drive.valid),
    .left_speed        (drive.left_speed),
    .right_speed       (drive.right_speed),
    .left_reverse      (drive.left_reverse),
    .right_reverse     (drive.right_reverse),
    .left_dir_changed  (drive.left_dir_changed),
    .right_dir_changed (drive.right_dir_changed)
  );

endmodule

@@ rtl/jddm_checker.sv @@
// Port-level checks of the mixer, bound to the top level.
`include "joystick_differential_drive_mixer_defines.svh"

module jddm_checker import jddm_pkg::*; (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input logic [DbW-1:0] left_speed,
  input logic [DbW-1:0] right_speed,
  input logic           left_chg,
  input logic           right_chg
);

  `JDDM_ASSERT_ALWAYS(a_reset_empty, clk, rst, !out_valid)
  `JDDM_ASSERT_NEXT(a_no_fast_word, clk, rst, in_valid && in_ready && !out_valid, !out_valid)
  `JDDM_ASSERT_NOW(a_left_chg_moves, clk, rst, out_valid && left_chg, left_speed != 8'd0)
  `JDDM_ASSERT_NOW(a_right_chg_moves, clk, rst, out_valid && right_chg, right_speed != 8'd0)
  `JDDM_ASSERT_NEXT(a_hold_stall, clk, rst, out_valid && !out_ready,
                    out_valid && $stable(left_speed) && $stable(right_speed))

endmodule

bind joystick_differential_drive_mixer jddm_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (stick.valid),
  .in_ready    (stick.ready),
  .out_valid   (drive.valid),
  .out_ready   (drive.ready),
  .left_speed  (drive.left_speed),
  .right_speed (drive.right_speed),
  .left_chg    (drive.left_dir_changed),
  .right_chg   (drive.right_dir_changed)
);
